/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a property holds on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert a property that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* rtl/hbtrl_pkg.sv */
// Package for the hashed bin time range lookup: payload types, codes, constants.
// Used by the top level and the port checker; depends on nothing.
package hbtrl_pkg;

  localparam int unsigned MaxBuckets = 1024;
  localparam int unsigned MaxPoints  = 65536;

  localparam logic [31:0] C1   = 32'hcc9e2d51;
  localparam logic [31:0] C2   = 32'h1b873593;
  localparam logic [31:0] CAdd = 32'he6546b64;
  localparam logic [31:0] Seed = 32'h8d0e03f0;
  localparam logic [31:0] F1   = 32'h85ebca6b;
  localparam logic [31:0] F2   = 32'hc2b2ae35;

  typedef enum logic [1:0] {
    CMD_WR_OFFSET = 2'd0,
    CMD_WR_TIME   = 2'd1,
    CMD_QUERY     = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [15:0]        entry_index;
    logic [16:0]        offset_value;
    logic signed [31:0] point_time;
    logic signed [31:0] lat_bin;
    logic signed [31:0] lon_bin;
    logic signed [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic [31:0] hash_value;
    logic [9:0]  bucket;
    logic [16:0] range_begin;
    logic [16:0] range_end;
    logic        found;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_KMUL1,  // k * C1 (shared multiplier)
    ST_KMUL2,  // rotl(k,15) * C2
    ST_HMIX,   // h ^= k, rotl, h*5 + CAdd
    ST_FMUL1,  // finalizer first multiply
    ST_FMUL2,  // finalizer second multiply
    ST_FDONE,
    ST_DIV,    // restoring modulo, one bit a cycle
    ST_RDLO,   // read bucket end
    ST_RDHI,   // read bucket begin
    ST_BNDS,
    ST_SMID,   // compute mid index
    ST_SWAIT,
    ST_SCMP,
    ST_DNRD,   // run extension downward
    ST_DNWT,
    ST_DNCK,
    ST_UPRD,   // run extension upward
    ST_UPWT,
    ST_UPCK,
    ST_OUT
  } state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

endpackage

/* rtl/hashed_bin_time_range_lookup.sv */
// Top level of the hashed bin time range lookup: hash, modulo, search, run scan.
// Depends on hbtrl_pkg.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_ready  hbtrl_pkg::in_item_t
//   out_     out  out_valid/out_ready hbtrl_pkg::out_item_t
//   cfg_     in   cfg_we             cfg_data[10:0] bucket total
//
// A load is written when it is accepted; a query runs the hash, the modulo,
// the bucket bound reads, then the search steps and the run elements checked one by one,
// then an output state, all set by the single sequencer with one shared 32x32
// multiplier and one read port per store.
// Reset (rst_n low, synchronous) clears control and sets the bucket total to 1024.
// in_ready is low while a query runs or a result waits; out_valid holds until taken.
module hashed_bin_time_range_lookup #(
  parameter int unsigned MAX_BUCKETS = hbtrl_pkg::MaxBuckets,
  parameter int unsigned MAX_POINTS  = hbtrl_pkg::MaxPoints
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hbtrl_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hbtrl_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [10:0]          cfg_data
);

  localparam int unsigned BW = (MAX_BUCKETS + 1 > 1) ? $clog2(MAX_BUCKETS + 1) : 1;
  localparam int unsigned PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  // stores
  logic [16:0] offs_mem [MAX_BUCKETS + 1];
  logic [31:0] pts_mem  [MAX_POINTS];
  logic [16:0] offs_q;
  logic [31:0] pts_q;
  logic [BW-1:0] offs_addr;
  logic [PW-1:0] pts_addr;

  hbtrl_pkg::state_t state_r, state_nxt;
  logic [10:0] bcount_r;
  hbtrl_pkg::in_item_t item_r, item_nxt;
  logic [31:0] h_r, h_nxt, k_r, k_nxt;
  logic [1:0]  round_r, round_nxt;
  logic [31:0] rem_r, rem_nxt;    // partial remainder, fits below 2*n
  logic [5:0]  bit_r, bit_nxt;
  logic [17:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, rb_r, rb_nxt, re_r, re_nxt;
  logic        hit_r, hit_nxt;
  hbtrl_pkg::out_item_t res_r, res_nxt;
  logic        ov_r, ov_nxt;

  logic [31:0] mul_a, mul_b, mul_p;
  logic [10:0] n_eff;
  logic [31:0] rem_sh;
  logic [17:0] clampd;
  logic [31:0] tkey, mkey;

  // shared multiplier
  assign mul_p = mul_a * mul_b;

  always_comb begin
    n_eff = (bcount_r == 11'd0) ? 11'd1 : bcount_r;
    if (32'(n_eff) > 32'(MAX_BUCKETS)) n_eff = 11'(MAX_BUCKETS);
  end

  assign rem_sh = {rem_r[30:0], h_r[bit_r[4:0]]};
  assign clampd = (32'(offs_q) > 32'(MAX_POINTS)) ? 18'(MAX_POINTS) : {1'b0, offs_q};
  assign tkey   = item_r.query_time ^ 32'h80000000;
  assign mkey   = pts_q ^ 32'h80000000;

  assign in_ready  = (state_r == hbtrl_pkg::ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      if (in_data.command == hbtrl_pkg::CMD_WR_OFFSET &&
          32'(in_data.entry_index) < 32'(MAX_BUCKETS + 1))
        offs_mem[BW'(in_data.entry_index)] <= in_data.offset_value;
      if (in_data.command == hbtrl_pkg::CMD_WR_TIME &&
          32'(in_data.entry_index) < 32'(MAX_POINTS))
        pts_mem[PW'(in_data.entry_index)] <= in_data.point_time;
    end
    offs_q <= offs_mem[offs_addr];
    pts_q  <= pts_mem[pts_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hbtrl_pkg::ST_IDLE;
      ov_r     <= 1'b0;
      bcount_r <= 11'd1024;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) bcount_r <= cfg_data;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt; h_r <= h_nxt; k_r <= k_nxt; round_r <= round_nxt;
    rem_r <= rem_nxt; bit_r <= bit_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    mid_r <= mid_nxt; rb_r <= rb_nxt; re_r <= re_nxt; hit_r <= hit_nxt;
    res_r <= res_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; item_nxt = item_r; h_nxt = h_r; k_nxt = k_r;
    round_nxt = round_r; rem_nxt = rem_r; bit_nxt = bit_r; lo_nxt = lo_r;
    hi_nxt = hi_r; mid_nxt = mid_r; rb_nxt = rb_r; re_nxt = re_r; hit_nxt = hit_r;
    res_nxt = res_r; ov_nxt = ov_r;
    mul_a = k_r; mul_b = hbtrl_pkg::C1;
    offs_addr = BW'(res_r.bucket);
    pts_addr = PW'(mid_r);
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      hbtrl_pkg::ST_IDLE: begin
        if (in_valid && in_ready && in_data.command == hbtrl_pkg::CMD_QUERY) begin
          item_nxt = in_data; h_nxt = hbtrl_pkg::Seed; round_nxt = 2'd0;
          k_nxt = in_data.lat_bin; state_nxt = hbtrl_pkg::ST_KMUL1;
        end
      end
      hbtrl_pkg::ST_KMUL1: begin
        mul_a = k_r; mul_b = hbtrl_pkg::C1;
        k_nxt = hbtrl_pkg::rotl(mul_p, 15); state_nxt = hbtrl_pkg::ST_KMUL2;
      end
      hbtrl_pkg::ST_KMUL2: begin
        mul_a = k_r; mul_b = hbtrl_pkg::C2;
        k_nxt = mul_p; state_nxt = hbtrl_pkg::ST_HMIX;
      end
      hbtrl_pkg::ST_HMIX: begin
        h_nxt = hbtrl_pkg::rotl(h_r ^ k_r, 13);
        h_nxt = (h_nxt << 2) + h_nxt + hbtrl_pkg::CAdd;
        round_nxt = round_r + 2'd1;
        if (round_r == 2'd2) begin
          state_nxt = hbtrl_pkg::ST_FMUL1;
        end else begin
          k_nxt = (round_r == 2'd0) ? item_r.lon_bin : item_r.query_time;
          state_nxt = hbtrl_pkg::ST_KMUL1;
        end
      end
      hbtrl_pkg::ST_FMUL1: begin
        mul_a = h_r ^ (h_r >> 16); mul_b = hbtrl_pkg::F1;
        h_nxt = mul_p; state_nxt = hbtrl_pkg::ST_FMUL2;
      end
      hbtrl_pkg::ST_FMUL2: begin
        mul_a = h_r ^ (h_r >> 13); mul_b = hbtrl_pkg::F2;
        h_nxt = mul_p; state_nxt = hbtrl_pkg::ST_FDONE;
      end
      hbtrl_pkg::ST_FDONE: begin
        h_nxt = h_r ^ (h_r >> 16); rem_nxt = '0; bit_nxt = 6'd31;
        state_nxt = hbtrl_pkg::ST_DIV;
      end
      hbtrl_pkg::ST_DIV: begin
        // restoring step: shift in one hash bit, subtract divisor if it fits
        rem_nxt = (rem_sh >= 32'(n_eff)) ? rem_sh - 32'(n_eff) : rem_sh;
        bit_nxt = bit_r - 6'd1;
        if (bit_r == 6'd0) begin
          res_nxt.hash_value = h_r;
          res_nxt.bucket = rem_nxt[9:0];
          offs_addr = BW'(rem_nxt);
          state_nxt = hbtrl_pkg::ST_RDLO;
        end
      end
      hbtrl_pkg::ST_RDLO: begin
        offs_addr = BW'(32'(res_r.bucket) + 32'd1);
        state_nxt = hbtrl_pkg::ST_RDHI;
      end
      // bucket end arrives here, bucket begin in the state after
      hbtrl_pkg::ST_RDHI: begin
        hi_nxt = clampd; state_nxt = hbtrl_pkg::ST_BNDS;
      end
      hbtrl_pkg::ST_BNDS: begin
        lo_nxt = clampd; hit_nxt = 1'b0; rb_nxt = '0; re_nxt = '0;
        state_nxt = hbtrl_pkg::ST_SMID;
      end
      hbtrl_pkg::ST_SMID: begin
        if (lo_r < hi_r) begin
          mid_nxt = lo_r + ((hi_r - lo_r) >> 1);
          state_nxt = hbtrl_pkg::ST_SWAIT;
        end else begin
          state_nxt = hbtrl_pkg::ST_OUT;
        end
      end
      hbtrl_pkg::ST_SWAIT: state_nxt = hbtrl_pkg::ST_SCMP;
      hbtrl_pkg::ST_SCMP: begin
        if (mkey < tkey) begin
          lo_nxt = mid_r + 18'd1; state_nxt = hbtrl_pkg::ST_SMID;
        end else if (mkey > tkey) begin
          hi_nxt = mid_r; state_nxt = hbtrl_pkg::ST_SMID;
        end else begin
          hit_nxt = 1'b1; rb_nxt = mid_r; re_nxt = mid_r + 18'd1;
          state_nxt = hbtrl_pkg::ST_DNRD;
        end
      end
      hbtrl_pkg::ST_DNRD: begin
        if (rb_r > lo_r) begin
          pts_addr = PW'(rb_r - 18'd1); state_nxt = hbtrl_pkg::ST_DNWT;
        end else begin
          state_nxt = hbtrl_pkg::ST_UPRD;
        end
      end
      // hold the read address so the data is valid in the check cycle
      hbtrl_pkg::ST_DNWT: begin
        pts_addr = PW'(rb_r - 18'd1); state_nxt = hbtrl_pkg::ST_DNCK;
      end
      hbtrl_pkg::ST_DNCK: begin
        if (pts_q == item_r.query_time) begin
          rb_nxt = rb_r - 18'd1; state_nxt = hbtrl_pkg::ST_DNRD;
        end else begin
          state_nxt = hbtrl_pkg::ST_UPRD;
        end
      end
      hbtrl_pkg::ST_UPRD: begin
        if (re_r < hi_r) begin
          pts_addr = PW'(re_r); state_nxt = hbtrl_pkg::ST_UPWT;
        end else begin
          state_nxt = hbtrl_pkg::ST_OUT;
        end
      end
      hbtrl_pkg::ST_UPWT: begin
        pts_addr = PW'(re_r); state_nxt = hbtrl_pkg::ST_UPCK;
      end
      hbtrl_pkg::ST_UPCK: begin
        if (pts_q == item_r.query_time) begin
          re_nxt = re_r + 18'd1; state_nxt = hbtrl_pkg::ST_UPRD;
        end else begin
          state_nxt = hbtrl_pkg::ST_OUT;
        end
      end
      hbtrl_pkg::ST_OUT: begin
        res_nxt.range_begin = rb_r[16:0];
        res_nxt.range_end = re_r[16:0];
        res_nxt.found = hit_r;
        ov_nxt = 1'b1;
        state_nxt = hbtrl_pkg::ST_IDLE;
      end
      default: state_nxt = hbtrl_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/hbtrl_checker.sv */
// Port checker for hashed_bin_time_range_lookup, bound to the top level.
// Depends on hbtrl_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hbtrl_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input hbtrl_pkg::out_item_t out_data
);
  // a pending result blocks new transfers
  `ASSERT_CLK(a_busy_out, clk, rst_n, out_valid |-> !in_ready, "in_ready while result pending")
  // a result holds until taken
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped")
  // a miss reports an empty range
  `ASSERT_CLK(a_miss, clk, rst_n, out_valid && !out_data.found |-> out_data.range_begin == 17'd0 && out_data.range_end == 17'd0, "miss range not zero")
  // a hit reports a nonempty range
  `ASSERT_CLK(a_hit, clk, rst_n, out_valid && out_data.found |-> out_data.range_begin < out_data.range_end, "empty hit range")
  // reset leaves no result pending
  `ASSERT_ALWAYS(a_rst, clk, !$past(rst_n) |-> !out_valid, "result after reset")
endmodule

bind hashed_bin_time_range_lookup hbtrl_checker u_hbtrl_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
